### src/sfpd_pkg.sv
`default_nettype none

package sfpd_pkg;

   localparam int BYTE_W      = 8;
   localparam int STORE_DEPTH = 16;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = ADDR_W + 1;
   localparam int MODE_W      = 2;

   // byte_count value once a palette table is complete
   localparam logic [COUNT_W-1:0] STORE_FULL = COUNT_W'(STORE_DEPTH);
   localparam logic [COUNT_W-1:0] LAST_ENTRY = COUNT_W'(STORE_DEPTH - 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_RAW     = 2'd0,
      MODE_MASK    = 2'd1,
      MODE_PALETTE = 2'd2,
      MODE_PLANAR  = 2'd3
   } decode_mode_type;

endpackage

`default_nettype wire

### src/sfpd_if.sv
`default_nettype none

interface sfpd_req_if import sfpd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface sfpd_rsp_if import sfpd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] pixel;
   logic              last_of_run;

   modport source (output valid, output pixel, output last_of_run, input ready);
   modport sink   (input valid, input pixel, input last_of_run, output ready);
endinterface

`default_nettype wire

### src/sfpd_ram.sv
`default_nettype none

module sfpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]              rd_data_a,
   output logic [WIDTH-1:0]              rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

### src/sprite_frame_pixel_decoder.sv
// The first pixel of a transaction passes the job register, then the output register, to rsp.
// Throughput (set by the single pixel emitter, one pixel per cycle unless rsp stalls):
//   raw 1 pixel/byte, mask 8 pixels/byte, palette lookup 2 pixels/byte; palette table
//   bytes and planar bytes give none, except every 16th planar byte: 16 pixels for its burst.
// Next req is taken in the cycle the current job's last pixel enters the output register.
// Reset: mode raw, byte count 0, pipeline empty; byte store undefined until written.
`default_nettype none

module sprite_frame_pixel_decoder import sfpd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   sfpd_req_if.sink               req_chan,
   sfpd_rsp_if.source             rsp_chan,
   input  wire logic              csr_wr_en,
   input  wire logic [MODE_W-1:0] csr_wr_data
);

   typedef enum logic [1:0] {
      JOB_RAW,
      JOB_MASK,
      JOB_PALETTE,
      JOB_PLANAR
   } job_kind_type;

   decode_mode_type   mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0] plane_ff [STORE_DEPTH];

   logic              job_valid_ff, job_valid_in;
   job_kind_type      job_kind_ff, job_kind_in;
   logic [BYTE_W-1:0] job_data_ff, job_data_in;
   logic [ADDR_W-1:0] job_idx_ff, job_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic              rsp_last_ff, rsp_last_in;

   logic               req_accept;
   logic [COUNT_W-1:0] cnt_base;
   logic [COUNT_W-1:0] gather_idx;
   logic [COUNT_W-1:0] count_next;
   logic               store_wr;
   logic [ADDR_W-1:0]  store_addr;
   logic               pal_rd;
   logic               emit_item;
   job_kind_type       emit_kind;

   logic              out_load;
   logic              job_step;
   logic              job_done;
   logic [ADDR_W-1:0] job_last;
   logic [BYTE_W-1:0] job_pixel;
   logic [BYTE_W-1:0] planar_pix;
   logic [BYTE_W-1:0] pal_hi;
   logic [BYTE_W-1:0] pal_lo;

   assign req_accept = req_chan.valid && req_chan.ready;

   // byte count / store update for the incoming byte
   always_comb begin
      cnt_base   = req_chan.frame_start ? '0 : count_ff;
      // planar gathering restarts a count left full by palette mode
      gather_idx = (cnt_base >= STORE_FULL) ? '0 : cnt_base;
      store_wr   = 1'b0;
      store_addr = cnt_base[ADDR_W-1:0];
      pal_rd     = 1'b0;
      emit_item  = 1'b0;
      emit_kind  = JOB_RAW;
      count_next = cnt_base;
      unique case (mode_ff)
         MODE_RAW: begin
            emit_item = 1'b1;
            emit_kind = JOB_RAW;
         end
         MODE_MASK: begin
            emit_item = 1'b1;
            emit_kind = JOB_MASK;
         end
         MODE_PALETTE: begin
            if (cnt_base < STORE_FULL) begin
               store_wr   = 1'b1;
               count_next = cnt_base + COUNT_W'(1);
            end else begin
               pal_rd    = 1'b1;
               emit_item = 1'b1;
               emit_kind = JOB_PALETTE;
            end
         end
         MODE_PLANAR: begin
            store_wr   = 1'b1;
            store_addr = gather_idx[ADDR_W-1:0];
            if (gather_idx == LAST_ENTRY) begin
               emit_item  = 1'b1;
               emit_kind  = JOB_PLANAR;
               count_next = '0;
            end else begin
               count_next = gather_idx + COUNT_W'(1);
            end
         end
         default: begin
            emit_item = 1'b0;
         end
      endcase
   end

   assign mode_in  = csr_wr_en ? decode_mode_type'(csr_wr_data) : mode_ff;
   assign count_in = req_accept ? count_next : count_ff;

   // palette table, looked up at two nibble addresses
   sfpd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (req_accept && store_wr),
      .wr_addr   (store_addr),
      .wr_data   (req_chan.data_byte),
      .rd_en     (req_accept && pal_rd),
      .rd_addr_a (req_chan.data_byte[BYTE_W-1 -: ADDR_W]),
      .rd_addr_b (req_chan.data_byte[ADDR_W-1:0]),
      .rd_data_a (pal_hi),
      .rd_data_b (pal_lo)
   );

   // emitter
   assign out_load = !rsp_valid_ff || rsp_chan.ready;
   assign job_step = job_valid_ff && out_load;

   always_comb begin
      unique case (job_kind_ff)
         JOB_RAW:     job_last = ADDR_W'(0);
         JOB_MASK:    job_last = ADDR_W'(BYTE_W - 1);
         JOB_PALETTE: job_last = ADDR_W'(1);
         JOB_PLANAR:  job_last = ADDR_W'(STORE_DEPTH - 1);
         default:     job_last = ADDR_W'(0);
      endcase
   end

   assign job_done       = job_step && (job_idx_ff == job_last);
   assign req_chan.ready = !job_valid_ff || job_done;

   // bit p of pixel j comes from byte 2p + j/8, bit 7 - j%8
   always_comb begin
      for (int p = 0; p < BYTE_W; p++) begin
         planar_pix[p] = plane_ff[{p[ADDR_W-2:0], job_idx_ff[ADDR_W-1]}][~job_idx_ff[2:0]];
      end
   end

   always_comb begin
      unique case (job_kind_ff)
         JOB_RAW:     job_pixel = job_data_ff;
         JOB_MASK:    job_pixel = {{(BYTE_W-1){1'b0}}, ~job_data_ff[~job_idx_ff[2:0]]};
         JOB_PALETTE: job_pixel = job_idx_ff[0] ? pal_lo : pal_hi;
         JOB_PLANAR:  job_pixel = planar_pix;
         default:     job_pixel = job_data_ff;
      endcase
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      job_idx_in   = job_idx_ff;
      job_kind_in  = job_kind_ff;
      job_data_in  = job_data_ff;
      if (job_done) begin
         job_valid_in = 1'b0;
      end else if (job_step) begin
         job_idx_in = job_idx_ff + ADDR_W'(1);
      end
      if (req_accept) begin
         job_valid_in = emit_item;
         job_idx_in   = '0;
         job_kind_in  = emit_kind;
         job_data_in  = req_chan.data_byte;
      end
   end

   assign rsp_valid_in = out_load ? job_valid_ff : rsp_valid_ff;
   assign rsp_pixel_in = job_step ? job_pixel : rsp_pixel_ff;
   assign rsp_last_in  = job_step ? (job_idx_ff == job_last) : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RAW;
         count_ff     <= '0;
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_idx_ff   <= job_idx_in;
      job_kind_ff  <= job_kind_in;
      job_data_ff  <= job_data_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
      if (req_accept && store_wr) begin
         plane_ff[store_addr] <= req_chan.data_byte;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel       = rsp_pixel_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= STORE_FULL)
      else $error("byte count beyond store depth");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (job_idx_ff <= job_last))
      else $error("pixel index past end of job");

   a_job_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && emit_item) |=> (job_valid_ff && job_idx_ff == '0))
      else $error("emitting transaction did not start a job");

   a_planar_reset: assert property (@(posedge clock) disable iff (reset)
      (req_accept && mode_ff == MODE_PLANAR && emit_item) |=> (count_ff == '0))
      else $error("planar group emitted without clearing byte count");

   a_last_ends_job: assert property (@(posedge clock) disable iff (reset)
      (job_step && job_idx_ff == job_last && !req_accept) |=> !job_valid_ff)
      else $error("job still active after its last pixel");

endmodule

`default_nettype wire

### dv/sfpd_checker.sv
`timescale 1ns / 1ps

module sfpd_checker import sfpd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   sfpd_req_if               req_mon,
   sfpd_rsp_if               rsp_mon,
   input  logic              csr_wr_en,
   input  logic [MODE_W-1:0] csr_wr_data,
   output int                fail_count,
   output int                pending
);

   typedef struct packed {
      logic [BYTE_W-1:0] pixel;
      logic              last_of_run;
   } pixel_type;

   decode_mode_type    mode_q;
   logic [BYTE_W-1:0]  byte_store_q [STORE_DEPTH];
   logic [COUNT_W-1:0] byte_count_q;
   pixel_type          expected_pixels [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (fail_count < 40) begin
         $display("checker: %s got %0h expected %0h at %0t ns", what, got, want, $time);
      end
      fail_count++;
   endtask

   // expected pixels caused by one accepted byte
   task automatic decode_byte(input logic [BYTE_W-1:0] d, input logic frame_start);
      pixel_type         pix;
      logic [BYTE_W-1:0] plane_byte;
      int                j;
      int                p;
      if (frame_start) byte_count_q = '0;
      case (mode_q)
         MODE_RAW: begin
            pix.pixel       = d;
            pix.last_of_run = 1'b1;
            expected_pixels.push_back(pix);
         end
         MODE_MASK: begin
            for (j = 0; j < 8; j++) begin
               pix.pixel       = d[7-j] ? 8'h00 : 8'h01;
               pix.last_of_run = (j == 7);
               expected_pixels.push_back(pix);
            end
         end
         MODE_PALETTE: begin
            if (byte_count_q < STORE_FULL) begin
               byte_store_q[byte_count_q[ADDR_W-1:0]] = d;
               byte_count_q++;
            end else begin
               pix.pixel       = byte_store_q[d[7:4]];
               pix.last_of_run = 1'b0;
               expected_pixels.push_back(pix);
               pix.pixel       = byte_store_q[d[3:0]];
               pix.last_of_run = 1'b1;
               expected_pixels.push_back(pix);
            end
         end
         default: begin
            // a full palette count left over restarts the group
            if (byte_count_q >= STORE_FULL) byte_count_q = '0;
            byte_store_q[byte_count_q[ADDR_W-1:0]] = d;
            byte_count_q++;
            if (byte_count_q == STORE_FULL) begin
               for (j = 0; j < 16; j++) begin
                  pix.pixel = '0;
                  for (p = 0; p < 8; p++) begin
                     plane_byte   = byte_store_q[2*p + j/8];
                     pix.pixel[p] = plane_byte[7 - (j % 8)];
                  end
                  pix.last_of_run = (j == 15);
                  expected_pixels.push_back(pix);
               end
               byte_count_q = '0;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      pixel_type want;
      if (reset) begin
         mode_q       = MODE_RAW;
         byte_count_q = '0;
         expected_pixels.delete();
      end else begin
         if (csr_wr_en) mode_q = decode_mode_type'(csr_wr_data);
         if (req_mon.valid && req_mon.ready) begin
            decode_byte(req_mon.data_byte, req_mon.frame_start);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected pixel", rsp_mon.pixel, 0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_mon.pixel !== want.pixel) begin
                  report_mismatch("pixel", rsp_mon.pixel, want.pixel);
               end
               if (rsp_mon.last_of_run !== want.last_of_run) begin
                  report_mismatch("last_of_run", rsp_mon.last_of_run, want.last_of_run);
               end
            end
         end
      end
      pending = expected_pixels.size();
   end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import sfpd_pkg::*;

   localparam int RANDOM_ITEMS = 435;
   localparam int HOLD_CYCLES  = 300;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [MODE_W-1:0] csr_wr_data;
   int                fail_count;
   int                pending;
   int                sent;
   bit                tx_steady;
   bit                hold_rsp;

   sfpd_req_if req_bus ();
   sfpd_rsp_if rsp_bus ();

   sprite_frame_pixel_decoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   sfpd_checker pixel_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int idle_cycles(input bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic push_byte(input logic [BYTE_W-1:0] d, input logic frame_start);
      int gap;
      gap = idle_cycles(tx_steady);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= d;
      req_bus.frame_start <= frame_start;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // drain every outstanding pixel, then let table/group bytes finish
   task automatic drain;
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_mode(input decode_mode_type mode);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(input bit start_frame, input int len);
      int                i;
      int                r;
      logic [BYTE_W-1:0] d;
      logic              fs;
      for (i = 0; i < len; i++) begin
         fs = (i == 0 && start_frame) || ($urandom_range(0, 39) == 0);
         r  = $urandom_range(0, 15);
         if (r == 0)      d = 8'h00;
         else if (r == 1) d = 8'hFF;
         else             d = 8'($urandom_range(0, 255));
         push_byte(d, fs);
      end
   endtask

   // response side: random back-pressure plus one long hold-off
   initial begin : pixel_sink
      int run;
      int gap;
      int k;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            for (k = 0; k < HOLD_CYCLES; k++) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_bus.ready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
         repeat (run) begin
            @(negedge clock);
            if (hold_rsp) break;
         end
         if (!hold_rsp) begin
            gap = idle_cycles(1'b0);
            if (gap > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int              i;
      int              phase;
      int              len;
      int              target;
      bit              start_frame;
      decode_mode_type mode;

      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = '0;
      req_bus.frame_start = 1'b0;
      sent                = 0;
      tx_steady           = 1'b0;
      hold_rsp            = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: raw, mask extremes, then a full palette and a few lookups
      set_mode(MODE_RAW);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h5A, 1'b1);
      set_mode(MODE_MASK);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h96, 1'b0);
      set_mode(MODE_PALETTE);
      for (i = 0; i < STORE_DEPTH; i++) push_byte(8'(i * 17), i == 0);
      push_byte(8'h0F, 1'b0);
      push_byte(8'hF0, 1'b0);
      push_byte(8'h3C, 1'b0);

      target = sent + RANDOM_ITEMS;
      phase  = 0;
      while (sent < target) begin
         start_frame = 1'b1;
         case (phase)
            0:       mode = MODE_PLANAR;
            1:       mode = MODE_PALETTE;
            2: begin
               // full palette count carried into planar mode
               mode        = MODE_PLANAR;
               start_frame = 1'b0;
            end
            3:       mode = MODE_MASK;
            default: begin
               mode        = decode_mode_type'($urandom_range(0, 3));
               start_frame = ($urandom_range(0, 3) != 0);
            end
         endcase
         case (mode)
            MODE_RAW:     len = $urandom_range(10, 40);
            MODE_MASK:    len = $urandom_range(5, 20);
            MODE_PALETTE: len = STORE_DEPTH + $urandom_range(4, 20);
            default:      len = STORE_DEPTH * $urandom_range(1, 3) + $urandom_range(0, 8);
         endcase
         set_mode(mode);
         tx_steady = ($urandom_range(0, 3) == 0);
         if (phase == 3) begin
            len       = 60;
            tx_steady = 1'b1;
            hold_rsp  = 1'b1;
         end
         if (len > target - sent) len = target - sent;
         run_phase(start_frame, len);
         phase++;
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
